// ----- design/csvfs_pkg.sv -----
package csvfs_pkg;

   // Default depth of the trailing-whitespace store
   localparam int MAX_HELD_SPACES_DEFAULT = 16;

   localparam logic [7:0] BYTE_DQUOTE = 8'h22;
   localparam logic [7:0] BYTE_COMMA  = 8'h2C;
   localparam logic [7:0] BYTE_LEAD   = 8'hE2;  // first byte of a typographic quote
   localparam logic [7:0] BYTE_MID    = 8'h80;  // second byte of a typographic quote
   localparam logic [7:0] BYTE_OPENQ  = 8'h9C;
   localparam logic [7:0] BYTE_CLOSEQ = 8'h9D;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_line;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       field_end;
      logic       line_end;
      logic       overflow;
   } rsp_type;

   // Classified symbol handed from front to back
   typedef struct packed {
      logic       is_close;   // close a field
      logic       line_end;   // with is_close: the field closes the line
      logic [7:0] value;      // field byte when not a close
   } sym_type;

   function automatic logic is_space(input logic [7:0] c);
      return c inside {8'h20, [8'h09:8'h0D]};
   endfunction

endpackage

// ----- design/csvfs_front.sv -----
module csvfs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  csvfs_pkg::req_type  req_data,
   output logic                req_full,
   input  logic                sym_full,
   output logic                sym_push,
   output csvfs_pkg::sym_type  sym_wr
);

   // Step slots, replayed lowest first
   localparam int STEP_LEAD_A = 0;
   localparam int STEP_MID_A  = 1;
   localparam int STEP_BYTE   = 2;
   localparam int STEP_LEAD_B = 3;
   localparam int STEP_MID_B  = 4;
   localparam int STEP_CLOSE  = 5;
   localparam int STEPS       = 6;

   localparam logic [1:0] PFX_NONE = 2'd0;
   localparam logic [1:0] PFX_ONE  = 2'd1;
   localparam logic [1:0] PFX_TWO  = 2'd2;

   logic [STEPS-1:0] pend_ff, pend_in, pend_rest, low, new_pend;
   logic [7:0]       fb_ff, fb_in, new_fb, step_byte;
   logic [1:0]       prefix_ff, prefix_in, new_prefix;
   logic             quoted_ff, quoted_in, held_ff, held_in;
   logic             go, accept, q_eff;

   assign go        = (pend_ff != '0) && !sym_full;
   assign low       = pend_ff & (~pend_ff + 1'b1);
   assign pend_rest = go ? (pend_ff & ~low) : pend_ff;
   assign req_full  = (pend_rest != '0);
   assign accept    = req_push && !req_full;

   always_comb begin
      if (low[STEP_LEAD_A] || low[STEP_LEAD_B]) begin
         step_byte = csvfs_pkg::BYTE_LEAD;
      end else if (low[STEP_MID_A] || low[STEP_MID_B]) begin
         step_byte = csvfs_pkg::BYTE_MID;
      end else begin
         step_byte = fb_ff;
      end
   end

   // Decode an incoming item into its list of steps
   always_comb begin
      new_pend   = '0;
      new_fb     = fb_ff;
      new_prefix = prefix_ff;
      if (req_data.has_byte) begin
         if (prefix_ff == PFX_ONE && req_data.data_byte == csvfs_pkg::BYTE_MID) begin
            new_prefix = PFX_TWO;
         end else if (prefix_ff == PFX_TWO &&
                      (req_data.data_byte == csvfs_pkg::BYTE_OPENQ ||
                       req_data.data_byte == csvfs_pkg::BYTE_CLOSEQ)) begin
            new_prefix          = PFX_NONE;
            new_pend[STEP_BYTE] = 1'b1;
            new_fb              = csvfs_pkg::BYTE_DQUOTE;
         end else begin
            new_pend[STEP_LEAD_A] = (prefix_ff != PFX_NONE);
            new_pend[STEP_MID_A]  = (prefix_ff == PFX_TWO);
            if (req_data.data_byte == csvfs_pkg::BYTE_LEAD) begin
               new_prefix = PFX_ONE;
            end else begin
               new_prefix          = PFX_NONE;
               new_pend[STEP_BYTE] = 1'b1;
               new_fb              = req_data.data_byte;
            end
         end
      end
      if (req_data.end_of_line) begin
         new_pend[STEP_LEAD_B] = (new_prefix != PFX_NONE);
         new_pend[STEP_MID_B]  = (new_prefix == PFX_TWO);
         new_pend[STEP_CLOSE]  = 1'b1;
         new_prefix            = PFX_NONE;
      end
   end

   assign pend_in   = accept ? new_pend : pend_rest;
   assign fb_in     = accept ? new_fb : fb_ff;
   assign prefix_in = accept ? new_prefix : prefix_ff;

   // Quote handling on the current step
   always_comb begin
      q_eff     = quoted_ff;
      quoted_in = quoted_ff;
      held_in   = held_ff;
      sym_push  = 1'b0;
      sym_wr    = '0;
      if (go) begin
         if (low[STEP_CLOSE]) begin
            sym_push        = 1'b1;
            sym_wr.is_close = 1'b1;
            sym_wr.line_end = 1'b1;
            held_in         = 1'b0;
            quoted_in       = 1'b0;
         end else if (held_ff && step_byte == csvfs_pkg::BYTE_DQUOTE) begin
            held_in      = 1'b0;
            sym_push     = 1'b1;
            sym_wr.value = csvfs_pkg::BYTE_DQUOTE;
         end else begin
            if (held_ff) begin
               held_in   = 1'b0;
               q_eff     = 1'b0;
               quoted_in = 1'b0;
            end
            if (step_byte == csvfs_pkg::BYTE_DQUOTE) begin
               if (q_eff) begin
                  held_in = 1'b1;
               end else begin
                  quoted_in = 1'b1;
               end
            end else if (step_byte == csvfs_pkg::BYTE_COMMA && !q_eff) begin
               sym_push        = 1'b1;
               sym_wr.is_close = 1'b1;
            end else begin
               sym_push     = 1'b1;
               sym_wr.value = step_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= '0;
         prefix_ff <= PFX_NONE;
         quoted_ff <= 1'b0;
         held_ff   <= 1'b0;
      end else begin
         pend_ff   <= pend_in;
         prefix_ff <= prefix_in;
         quoted_ff <= quoted_in;
         held_ff   <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      fb_ff <= fb_in;
   end

endmodule

// ----- design/csvfs_sym_queue.sv -----
module csvfs_sym_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  csvfs_pkg::sym_type  push_sym,
   output logic                full,
   input  logic                pop,
   output csvfs_pkg::sym_type  pop_sym,
   output logic                empty
);

   localparam int Depth = 4;
   localparam int PtrW  = $clog2(Depth);
   localparam int CntW  = $clog2(Depth + 1);

   csvfs_pkg::sym_type slot_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign full    = (cnt_ff == CntW'(Depth));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_sym = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign cnt_in    = cnt_ff + CntW'(do_push) - CntW'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_sym;
      end
   end

endmodule

// ----- design/csvfs_back.sv -----
module csvfs_back #(
   parameter int MaxHeld = csvfs_pkg::MAX_HELD_SPACES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                sym_empty,
   input  csvfs_pkg::sym_type  sym_rd,
   output logic                sym_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output csvfs_pkg::rsp_type  rsp_data
);

   localparam int PtrW     = (MaxHeld > 1) ? $clog2(MaxHeld) : 1;
   localparam int CntW     = $clog2(MaxHeld + 1);
   localparam int OutDepth = 4;
   localparam int OPtrW    = $clog2(OutDepth);
   localparam int OCntW    = $clog2(OutDepth + 1);

   // Trailing-whitespace store, circular
   logic [7:0]      space_mem [MaxHeld];
   logic [7:0]      rd_data_ff;
   logic [PtrW-1:0] head_ff, head_in, tail_ff, tail_in, head_next, tail_next;
   logic [CntW-1:0] count_ff, count_in;
   logic            content_ff, content_in;
   logic            rdv_ff, rdv_in, rdov_ff, rdov_in;
   logic            wr_en;

   // Result queue
   csvfs_pkg::rsp_type out_ff [OutDepth];
   logic [OPtrW-1:0]   out_wr_ff, out_rd_ff;
   logic [OCntW-1:0]   out_cnt_ff, out_cnt_in;
   logic               out_push, out_pop, room;
   csvfs_pkg::rsp_type out_wdata, direct_data;
   logic               direct_push;

   assign head_next = (head_ff == PtrW'(MaxHeld - 1)) ? '0 : head_ff + 1'b1;
   assign tail_next = (tail_ff == PtrW'(MaxHeld - 1)) ? '0 : tail_ff + 1'b1;

   // Space for one more result next cycle, counting the read in flight
   assign room = (out_cnt_ff + OCntW'(rdv_ff)) < OCntW'(OutDepth);

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      content_in  = content_ff;
      rdv_in      = 1'b0;
      rdov_in     = 1'b0;
      wr_en       = 1'b0;
      sym_pop     = 1'b0;
      direct_push = 1'b0;
      direct_data = '0;
      if (!sym_empty) begin
         if (sym_rd.is_close) begin
            if (!rdv_ff && room) begin
               direct_push           = 1'b1;
               direct_data.field_end = 1'b1;
               direct_data.line_end  = sym_rd.line_end;
               head_in               = tail_ff;
               count_in              = '0;
               content_in            = 1'b0;
               sym_pop               = 1'b1;
            end
         end else if (csvfs_pkg::is_space(sym_rd.value)) begin
            if (!content_ff) begin
               sym_pop = 1'b1;
            end else if (count_ff != CntW'(MaxHeld)) begin
               wr_en    = 1'b1;
               tail_in  = tail_next;
               count_in = count_ff + 1'b1;
               sym_pop  = 1'b1;
            end else if (room) begin
               rdv_in  = 1'b1;
               rdov_in = 1'b1;
               head_in = head_next;
               wr_en   = 1'b1;
               tail_in = tail_next;
               sym_pop = 1'b1;
            end
         end else if (count_ff != '0) begin
            if (room) begin
               rdv_in   = 1'b1;
               head_in  = head_next;
               count_in = count_ff - 1'b1;
            end
         end else if (!rdv_ff && room) begin
            direct_push            = 1'b1;
            direct_data.out_byte   = sym_rd.value;
            direct_data.byte_valid = 1'b1;
            content_in             = 1'b1;
            sym_pop                = 1'b1;
         end
      end
   end

   always_comb begin
      if (rdv_ff) begin
         out_wdata            = '0;
         out_wdata.out_byte   = rd_data_ff;
         out_wdata.byte_valid = 1'b1;
         out_wdata.overflow   = rdov_ff;
      end else begin
         out_wdata = direct_data;
      end
   end

   assign out_push   = rdv_ff || direct_push;
   assign rsp_empty  = (out_cnt_ff == '0);
   assign out_pop    = rsp_pop && !rsp_empty;
   assign rsp_data   = out_ff[out_rd_ff];
   assign out_cnt_in = out_cnt_ff + OCntW'(out_push) - OCntW'(out_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         content_ff <= 1'b0;
         rdv_ff     <= 1'b0;
         out_wr_ff  <= '0;
         out_rd_ff  <= '0;
         out_cnt_ff <= '0;
      end else begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         content_ff <= content_in;
         rdv_ff     <= rdv_in;
         out_cnt_ff <= out_cnt_in;
         if (out_push) begin
            out_wr_ff <= out_wr_ff + 1'b1;
         end
         if (out_pop) begin
            out_rd_ff <= out_rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rdov_ff    <= rdov_in;
      rd_data_ff <= space_mem[head_ff];
      if (wr_en) begin
         space_mem[tail_ff] <= sym_rd.value;
      end
      if (out_push) begin
         out_ff[out_wr_ff] <= out_wdata;
      end
   end

endmodule

// ----- design/csv_field_splitter.sv -----
// Channel   Ports                          Transaction
// -------   ----------------------------   -----------------------------------------
// request   req_push, req_full, req_data   one raw byte and/or end-of-line marker
// response  rsp_pop, rsp_empty, rsp_data   one field byte or a bare field/line marker
//
// Ordinary bytes stream at one transaction per cycle in both directions unless a
// queue fills or held whitespace stalls the back. An item that replays a broken
// E2 / E2 80 prefix or closes a line holds the front for each of its steps (byte,
// replayed prefix byte, close), four at most. The back sends held whitespace first.
// Reset is synchronous and clears control state, not the whitespace store.
// Either side may stall for any time; both queues hold what is in flight.
module csv_field_splitter #(
   parameter int MAX_HELD_SPACES = csvfs_pkg::MAX_HELD_SPACES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  csvfs_pkg::req_type  req_data,
   output logic                req_full,
   input  logic                rsp_pop,
   output csvfs_pkg::rsp_type  rsp_data,
   output logic                rsp_empty
);

   logic               sym_push, sym_full, sym_pop, sym_empty;
   csvfs_pkg::sym_type sym_wr, sym_rd;

   // Front: decode typographic quotes, track quoted mode, split on commas
   csvfs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .sym_full (sym_full),
      .sym_push (sym_push),
      .sym_wr   (sym_wr)
   );

   // Decouple front from back so each can stall on its own
   csvfs_sym_queue u_sym_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (sym_push),
      .push_sym (sym_wr),
      .full     (sym_full),
      .pop      (sym_pop),
      .pop_sym  (sym_rd),
      .empty    (sym_empty)
   );

   // Back: trim whitespace at both ends of each field, emit results
   csvfs_back #(
      .MaxHeld (MAX_HELD_SPACES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .sym_empty (sym_empty),
      .sym_rd    (sym_rd),
      .sym_pop   (sym_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // The front must never push a symbol into a full queue
   a_sym_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(sym_push && sym_full))
      else $error("symbol pushed into full queue");

   // The back must never take a symbol that is not there
   a_sym_no_underrun: assert property (@(posedge clock) disable iff (reset)
      !(sym_pop && sym_empty))
      else $error("symbol popped from empty queue");

   // A field marker is bare, and a line end always closes a field
   a_marker_shape: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && (rsp_data.field_end || rsp_data.line_end) |->
         rsp_data.field_end && !rsp_data.byte_valid && !rsp_data.overflow)
      else $error("malformed field marker");

   // An overflow result always carries a whitespace byte
   a_overflow_ws: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.overflow |->
         rsp_data.byte_valid && csvfs_pkg::is_space(rsp_data.out_byte))
      else $error("overflow on a non-whitespace result");

endmodule

// ----- dv/csv_field_splitter_tb.sv -----
module csv_field_splitter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 10;
   localparam int HELD_MAX = csvfs_pkg::MAX_HELD_SPACES_DEFAULT;
   localparam int RANDOM_ITEMS = 260;
   localparam int DRAIN_CYCLES = 40;

   // Whitespace bytes: space plus the control range from tab to carriage return
   localparam logic [7:0] SPACE_BYTE = 8'h20;
   localparam logic [7:0] TAB_BYTE   = 8'h09;
   localparam logic [7:0] CR_BYTE    = 8'h0D;

   typedef enum logic [1:0] {LEAD_NONE, LEAD_E2, LEAD_E2_80} lead_type;
   typedef enum logic [1:0] {POP_STEADY, POP_SPARSE, POP_COIN, POP_STALL_RUNS} pop_mode_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   csvfs_pkg::req_type req_data = '0;
   logic               req_full;
   logic               rsp_pop = 1'b0;
   csvfs_pkg::rsp_type rsp_data;
   logic               rsp_empty;

   csv_field_splitter dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty)
   );

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------
   // Field splitter prediction: mirror of the block's line state.
   // ------------------------------------------------------------------
   bit                 in_quotes;      // inside a quoted section
   bit                 quote_pending;  // quote seen inside quotes, waiting for the next char
   bit                 seen_text;      // field already has non-whitespace content
   lead_type           lead_stage;     // partial typographic-quote prefix being held
   logic [7:0]         held_blanks[$]; // trailing whitespace held back for trimming
   csvfs_pkg::rsp_type awaited_out[$]; // field bytes and markers still to come out

   int unsigned mismatches;
   int unsigned results_checked;
   int unsigned early_releases;
   int unsigned lines_sent;
   int unsigned items_sent;

   function automatic bit is_blank(logic [7:0] c);
      return c == SPACE_BYTE || (c >= TAB_BYTE && c <= CR_BYTE);
   endfunction

   function automatic void put_out(logic [7:0] b, bit valid, bit fe, bit le, bit ov);
      csvfs_pkg::rsp_type r;
      r.out_byte   = b;
      r.byte_valid = valid;
      r.field_end  = fe;
      r.line_end   = le;
      r.overflow   = ov;
      awaited_out = {awaited_out, r};
   endfunction

   // Drop leading whitespace, hold trailing whitespace until content follows.
   function automatic void trim_byte(logic [7:0] c);
      if (is_blank(c)) begin
         if (!seen_text)
            return;
         // Store full: the oldest held byte leaves early and stays in the field
         if (held_blanks.size() >= HELD_MAX)
            put_out(held_blanks.pop_front(), 1'b1, 1'b0, 1'b0, 1'b1);
         held_blanks = {held_blanks, c};
         return;
      end
      foreach (held_blanks[i])
         put_out(held_blanks[i], 1'b1, 1'b0, 1'b0, 1'b0);
      held_blanks.delete();
      seen_text = 1'b1;
      put_out(c, 1'b1, 1'b0, 1'b0, 1'b0);
   endfunction

   function automatic void close_field(bit le);
      held_blanks.delete();
      seen_text = 1'b0;
      put_out(8'h00, 1'b0, 1'b1, le, 1'b0);
   endfunction

   // Quote handling: toggle quoted mode, fold doubled quotes, split on commas.
   function automatic void unquote_byte(logic [7:0] c);
      if (quote_pending) begin
         quote_pending = 1'b0;
         if (c == csvfs_pkg::BYTE_DQUOTE) begin
            trim_byte(csvfs_pkg::BYTE_DQUOTE);
            return;
         end
         in_quotes = 1'b0;
      end
      if (c == csvfs_pkg::BYTE_DQUOTE) begin
         if (in_quotes)
            quote_pending = 1'b1;
         else
            in_quotes = 1'b1;
      end else if (c == csvfs_pkg::BYTE_COMMA && !in_quotes) begin
         close_field(1'b0);
      end else begin
         trim_byte(c);
      end
   endfunction

   // Replay a broken E2 / E2 80 prefix as ordinary bytes.
   function automatic void flush_lead();
      if (lead_stage != LEAD_NONE)
         unquote_byte(csvfs_pkg::BYTE_LEAD);
      if (lead_stage == LEAD_E2_80)
         unquote_byte(csvfs_pkg::BYTE_MID);
      lead_stage = LEAD_NONE;
   endfunction

   function automatic void decode_byte(logic [7:0] b);
      if (lead_stage == LEAD_E2 && b == csvfs_pkg::BYTE_MID) begin
         lead_stage = LEAD_E2_80;
         return;
      end
      if (lead_stage == LEAD_E2_80 &&
          (b == csvfs_pkg::BYTE_OPENQ || b == csvfs_pkg::BYTE_CLOSEQ)) begin
         lead_stage = LEAD_NONE;
         unquote_byte(csvfs_pkg::BYTE_DQUOTE);
         return;
      end
      flush_lead();
      if (b == csvfs_pkg::BYTE_LEAD)
         lead_stage = LEAD_E2;
      else
         unquote_byte(b);
   endfunction

   function automatic void split_item(csvfs_pkg::req_type item);
      if (item.has_byte)
         decode_byte(item.data_byte);
      if (item.end_of_line) begin
         // Line end: replay any prefix, drop quote state, close the last field
         flush_lead();
         quote_pending = 1'b0;
         in_quotes = 1'b0;
         close_field(1'b1);
         lead_stage = LEAD_NONE;
      end
   endfunction

   // ------------------------------------------------------------------
   // Request side: bursts of back-to-back transactions with random gaps.
   // ------------------------------------------------------------------
   int burst_left = 0;

   task automatic push_item(input csvfs_pkg::req_type item);
      if (burst_left == 0) begin
         // Drop push for a random gap, then start a new burst
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 16);
      end
      req_push <= 1'b1;
      req_data <= item;
      // Hold the transaction until an edge sees push high and full low
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      split_item(item);
      items_sent++;
      if (item.end_of_line)
         lines_sent++;
      burst_left--;
   endtask

   task automatic send_byte(input logic [7:0] b, input bit eol);
      csvfs_pkg::req_type item;
      item.data_byte   = b;
      item.has_byte    = 1'b1;
      item.end_of_line = eol;
      push_item(item);
   endtask

   task automatic end_line();
      csvfs_pkg::req_type item;
      item.data_byte   = 8'h00;
      item.has_byte    = 1'b0;
      item.end_of_line = 1'b1;
      push_item(item);
   endtask

   // Send a string one byte per transaction; optionally end the line on the last byte
   task automatic send_text(input string s, input bit eol_on_last);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], eol_on_last && i == s.len() - 1);
   endtask

   function automatic logic [7:0] pick_blank();
      return ($urandom_range(0, 1) == 0) ? SPACE_BYTE : 8'($urandom_range(TAB_BYTE, CR_BYTE));
   endfunction

   // Bias noise toward the bytes that steer the splitter
   function automatic logic [7:0] pick_noise_byte();
      case ($urandom_range(0, 9))
         0:       return csvfs_pkg::BYTE_DQUOTE;
         1:       return csvfs_pkg::BYTE_COMMA;
         2:       return csvfs_pkg::BYTE_LEAD;
         3:       return csvfs_pkg::BYTE_MID;
         4:       return ($urandom_range(0, 1) == 0) ? csvfs_pkg::BYTE_OPENQ
                                                     : csvfs_pkg::BYTE_CLOSEQ;
         5:       return pick_blank();
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Response side: check every popped transaction against the oldest
   // expectation, and stall on a pattern that changes mode at random.
   // ------------------------------------------------------------------
   pop_mode_type pop_mode = POP_STEADY;
   int pop_mode_left = 0;
   int stall_left = 0;

   task automatic report_field(input string name, input logic [7:0] want, input logic [7:0] got);
      $display("%0t: %s expected %02h actual %02h", $time, name, want, got);
      mismatches++;
   endtask

   task automatic check_field_out(input csvfs_pkg::rsp_type got);
      csvfs_pkg::rsp_type want;
      results_checked++;
      if (got.overflow)
         early_releases++;
      if (awaited_out.size() == 0) begin
         $display("%0t: result expected none actual %h", $time, got);
         mismatches++;
         return;
      end
      want = awaited_out.pop_front();
      if (got.out_byte !== want.out_byte)
         report_field("out_byte", want.out_byte, got.out_byte);
      if (got.byte_valid !== want.byte_valid)
         report_field("byte_valid", want.byte_valid, got.byte_valid);
      if (got.field_end !== want.field_end)
         report_field("field_end", want.field_end, got.field_end);
      if (got.line_end !== want.line_end)
         report_field("line_end", want.line_end, got.line_end);
      if (got.overflow !== want.overflow)
         report_field("overflow", want.overflow, got.overflow);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty)
            check_field_out(rsp_data);
         if (pop_mode_left == 0) begin
            pop_mode = pop_mode_type'($urandom_range(0, 3));
            pop_mode_left = $urandom_range(40, 300);
         end else begin
            pop_mode_left--;
         end
         case (pop_mode)
            POP_STEADY: rsp_pop <= 1'b1;
            POP_SPARSE: rsp_pop <= ($urandom_range(0, 3) == 0);
            POP_COIN:   rsp_pop <= $urandom_range(0, 1);
            default: begin
               // Long stalls broken by a single pop
               if (stall_left > 0) begin
                  rsp_pop <= 1'b0;
                  stall_left--;
               end else begin
                  rsp_pop <= 1'b1;
                  stall_left = $urandom_range(0, 24);
               end
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Bare items, extreme byte values and empty fields.
   task automatic test_field_markers();
      csvfs_pkg::req_type item;
      // A bare item without line end must produce nothing
      item = '0;
      push_item(item);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      // Comma together with line end: closes the field, then an empty last field
      send_byte(csvfs_pkg::BYTE_COMMA, 1'b1);
      end_line();
      send_text(",,", 1'b0);
      end_line();
   endtask

   // Quoted commas, doubled quotes, quote at line end, unclosed quote.
   task automatic test_quoting();
      // Comma as data, doubled quote as one literal, closing quote held at line end
      send_text("\",\"\"\"", 1'b1);
      // Quote opens and the line ends without closing it
      send_text("\"z", 1'b1);
   endtask

   // Typographic quotes and broken prefixes.
   task automatic test_typographic();
      send_byte(csvfs_pkg::BYTE_LEAD, 1'b0);
      send_byte(csvfs_pkg::BYTE_MID, 1'b0);
      send_byte(csvfs_pkg::BYTE_OPENQ, 1'b0);
      send_text("x,", 1'b0);
      send_byte(csvfs_pkg::BYTE_LEAD, 1'b0);
      send_byte(csvfs_pkg::BYTE_MID, 1'b0);
      send_byte(csvfs_pkg::BYTE_CLOSEQ, 1'b0);
      // Broken prefix E2 then a plain byte, E2 80 then a plain byte
      send_byte(csvfs_pkg::BYTE_LEAD, 1'b0);
      send_text("A", 1'b0);
      send_byte(csvfs_pkg::BYTE_LEAD, 1'b0);
      send_byte(csvfs_pkg::BYTE_MID, 1'b0);
      send_text("B", 1'b0);
      // Prefix still held when the line ends
      send_byte(csvfs_pkg::BYTE_LEAD, 1'b0);
      send_byte(csvfs_pkg::BYTE_MID, 1'b1);
   endtask

   // Trimming at both ends, whitespace inside quotes, store overflow.
   task automatic test_whitespace();
      send_text(" \ta b\t \"\t q \"", 1'b1);
      // One more blank than the store holds: the oldest leaves early and is kept
      send_text("c", 1'b0);
      for (int i = 0; i <= HELD_MAX; i++)
         send_byte(pick_blank(), i == HELD_MAX);
   endtask

   // Mostly well-formed lines with random content, the rest noise.
   task automatic test_random_lines();
      logic [7:0]         line_bytes[$];
      csvfs_pkg::req_type item;
      int unsigned sent;
      int nfields, kind, r, n;
      bit merge_eol;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         line_bytes.delete();
         if ($urandom_range(0, 19) == 0) begin
            // Stray bare item between lines
            item = '0;
            item.data_byte = 8'($urandom_range(0, 255));
            push_item(item);
         end
         if ($urandom_range(0, 99) < 15) begin
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) begin
               item.has_byte    = ($urandom_range(0, 9) != 0);
               item.data_byte   = pick_noise_byte();
               item.end_of_line = (i == n - 1);
               push_item(item);
               if (item.has_byte || item.end_of_line)
                  sent++;
            end
         end else begin
            nfields = $urandom_range(1, 4);
            for (int f = 0; f < nfields; f++) begin
               if (f > 0)
                  line_bytes = {line_bytes, csvfs_pkg::BYTE_COMMA};
               repeat ($urandom_range(0, 3)) line_bytes = {line_bytes, pick_blank()};
               kind = $urandom_range(0, 2);
               if (kind == 1) begin
                  line_bytes = {line_bytes, csvfs_pkg::BYTE_DQUOTE};
               end else if (kind == 2) begin
                  line_bytes = {line_bytes, csvfs_pkg::BYTE_LEAD, csvfs_pkg::BYTE_MID,
                                csvfs_pkg::BYTE_OPENQ};
               end
               if (kind != 0 && $urandom_range(0, 1) == 1)
                  repeat ($urandom_range(1, 2)) line_bytes = {line_bytes, pick_blank()};
               repeat ($urandom_range(0, 6)) begin
                  r = $urandom_range(0, 99);
                  if (r < 60) begin
                     line_bytes = {line_bytes, 8'($urandom_range(8'h30, 8'h7A))};
                  end else if (r < 75) begin
                     line_bytes = {line_bytes, pick_blank()};
                  end else if (r < 85 && kind != 0) begin
                     line_bytes = {line_bytes, csvfs_pkg::BYTE_COMMA};
                  end else if (r < 93 && kind != 0) begin
                     line_bytes = {line_bytes, csvfs_pkg::BYTE_DQUOTE, csvfs_pkg::BYTE_DQUOTE};
                  end else begin
                     line_bytes = {line_bytes, 8'($urandom_range(0, 255))};
                  end
               end
               if (kind != 0 && $urandom_range(0, 9) == 0) begin
                  // Leave the quote open
               end else if (kind == 1) begin
                  line_bytes = {line_bytes, csvfs_pkg::BYTE_DQUOTE};
               end else if (kind == 2) begin
                  line_bytes = {line_bytes, csvfs_pkg::BYTE_LEAD, csvfs_pkg::BYTE_MID};
                  line_bytes = {line_bytes, ($urandom_range(0, 1) == 0) ?
                                csvfs_pkg::BYTE_OPENQ : csvfs_pkg::BYTE_CLOSEQ};
               end
               if ($urandom_range(0, 99) < 12)
                  repeat ($urandom_range(HELD_MAX - 2, HELD_MAX + 4))
                     line_bytes = {line_bytes, pick_blank()};
               else
                  repeat ($urandom_range(0, 3)) line_bytes = {line_bytes, pick_blank()};
            end
            merge_eol = $urandom_range(0, 1);
            for (int i = 0; i < line_bytes.size(); i++) begin
               send_byte(line_bytes[i], merge_eol && i == line_bytes.size() - 1);
               sent++;
            end
            if (!merge_eol || line_bytes.size() == 0) begin
               end_line();
               sent++;
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int drain;
      mismatches      = 0;
      results_checked = 0;
      early_releases  = 0;
      lines_sent      = 0;
      items_sent      = 0;
      in_quotes       = 1'b0;
      quote_pending   = 1'b0;
      seen_text       = 1'b0;
      lead_stage      = LEAD_NONE;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_markers();
      test_quoting();
      test_typographic();
      test_whitespace();
      test_random_lines();
      req_push <= 1'b0;

      // Drain every pending result, then watch for stray ones
      while (awaited_out.size() != 0)
         @(posedge clock);
      for (drain = 0; drain < DRAIN_CYCLES; drain++)
         @(posedge clock);

      $display("Sent %0d transactions over %0d lines; checked %0d results,",
               items_sent, lines_sent, results_checked);
      $display("%0d of them whitespace released early by store overflow.", early_releases);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Hard limit well above the slowest legal run
   initial begin
      #20_000_000;
      $display("Timeout with %0d results still pending", awaited_out.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
